### rtl/core/sha1bsh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Shared types, constants and the microcode table of the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

   // datapath operations, one per control word
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_PUTB   = 4'd1;
   localparam logic [3:0] OP_PAD    = 4'd2;
   localparam logic [3:0] OP_LOAD   = 4'd3;
   localparam logic [3:0] OP_ROUND  = 4'd4;
   localparam logic [3:0] OP_ADD    = 4'd5;
   localparam logic [3:0] OP_ADDCLR = 4'd6;
   localparam logic [3:0] OP_LENGTH = 4'd7;
   localparam logic [3:0] OP_EMIT   = 4'd8;

   // branch conditions
   localparam logic [2:0] C_ALWAYS   = 3'd0;
   localparam logic [2:0] C_DISPATCH = 3'd1;
   localparam logic [2:0] C_FULL     = 3'd2;
   localparam logic [2:0] C_SPILL    = 3'd3;
   localparam logic [2:0] C_ROUNDS   = 3'd4;
   localparam logic [2:0] C_OUTFREE  = 3'd5;

   // program steps
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PUTB    = 4'd1;
   localparam logic [3:0] S_B_LOAD  = 4'd2;
   localparam logic [3:0] S_B_ROUND = 4'd3;
   localparam logic [3:0] S_B_ADD   = 4'd4;
   localparam logic [3:0] S_PAD     = 4'd5;
   localparam logic [3:0] S_X_LOAD  = 4'd6;
   localparam logic [3:0] S_X_ROUND = 4'd7;
   localparam logic [3:0] S_X_ADD   = 4'd8;
   localparam logic [3:0] S_LENGTH  = 4'd9;
   localparam logic [3:0] S_F_LOAD  = 4'd10;
   localparam logic [3:0] S_F_ROUND = 4'd11;
   localparam logic [3:0] S_F_ADD   = 4'd12;
   localparam logic [3:0] S_EMIT    = 4'd13;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [5:0] PAD_LIMIT  = 6'd56;

   localparam logic [0:4][31:0] CHAIN_INIT = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic       take;
      logic [3:0] op;
      logic [2:0] cond;
      logic [3:0] tgt_t;
      logic [3:0] tgt_f;
   } ucode_type;

   typedef struct packed {
      logic       take;
      logic [3:0] op;
   } ctl_type;

   typedef struct packed {
      logic blk_full;
      logic pad_spill;
      logic round_last;
      logic out_free;
   } status_type;

   function automatic ucode_type ucode_rom(input logic [3:0] addr);
      ucode_type w;
      case (addr)
         S_IDLE:    w = '{1'b1, OP_NONE,   C_DISPATCH, S_PUTB,    S_PAD};
         S_PUTB:    w = '{1'b0, OP_PUTB,   C_FULL,     S_B_LOAD,  S_IDLE};
         S_B_LOAD:  w = '{1'b0, OP_LOAD,   C_ALWAYS,   S_B_ROUND, S_B_ROUND};
         S_B_ROUND: w = '{1'b0, OP_ROUND,  C_ROUNDS,   S_B_ADD,   S_B_ADD};
         S_B_ADD:   w = '{1'b0, OP_ADDCLR, C_ALWAYS,   S_IDLE,    S_IDLE};
         S_PAD:     w = '{1'b0, OP_PAD,    C_SPILL,    S_X_LOAD,  S_LENGTH};
         S_X_LOAD:  w = '{1'b0, OP_LOAD,   C_ALWAYS,   S_X_ROUND, S_X_ROUND};
         S_X_ROUND: w = '{1'b0, OP_ROUND,  C_ROUNDS,   S_X_ADD,   S_X_ADD};
         S_X_ADD:   w = '{1'b0, OP_ADDCLR, C_ALWAYS,   S_LENGTH,  S_LENGTH};
         S_LENGTH:  w = '{1'b0, OP_LENGTH, C_ALWAYS,   S_F_LOAD,  S_F_LOAD};
         S_F_LOAD:  w = '{1'b0, OP_LOAD,   C_ALWAYS,   S_F_ROUND, S_F_ROUND};
         S_F_ROUND: w = '{1'b0, OP_ROUND,  C_ROUNDS,   S_F_ADD,   S_F_ADD};
         S_F_ADD:   w = '{1'b0, OP_ADD,    C_ALWAYS,   S_EMIT,    S_EMIT};
         S_EMIT:    w = '{1'b0, OP_EMIT,   C_OUTFREE,  S_IDLE,    S_IDLE};
         default:   w = '{1'b0, OP_NONE,   C_ALWAYS,   S_IDLE,    S_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream, one byte per input transfer. A message byte is
// taken in the idle step and packed in the put step; the byte that completes
// a 64-byte block then gets a compression, one round per cycle in the single
// shared round unit plus a load and a chaining add step. A finish transfer
// (tuser high) pads, writes the bit length and runs the last compression,
// after an extra one when the padding spills into a second block, and loads
// the digest into the result register once the previous one is taken. A new
// transfer is taken while a digest still waits at the output. After a digest
// the hasher is back in its initial state; reset starts a fresh message.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_value
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // hash_word0 .. hash_word4
);
   import sha1bsh_pkg::*;

   ctl_type    ctl;
   status_type status;

   assign req_tready = ctl.take;

   sha1bsh_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .status     (status),
      .ctl        (ctl)
   );

   sha1bsh_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a byte transfer is packed in the next cycle
   a_byte_put: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> ctl.op == OP_PUTB)
      else $error("byte transfer not followed by put");

   // a finish transfer starts the padding in the next cycle
   a_pad_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> ctl.op == OP_PAD)
      else $error("finish transfer not followed by padding");

   // the last round is always followed by the chaining add
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_ROUND && status.round_last |=>
         ctl.op == OP_ADD || ctl.op == OP_ADDCLR)
      else $error("rounds not closed by chaining add");

   // a digest issued into a free result register shows up as valid
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_EMIT && status.out_free |=> rsp_tvalid)
      else $error("digest lost at result register");

endmodule

### rtl/core/sha1bsh_seq.sv
// ----------------------------------------------------------------------------
// sha1bsh_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sha1bsh_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tuser,
   input  sha1bsh_pkg::status_type  status,
   output sha1bsh_pkg::ctl_type     ctl
);
   import sha1bsh_pkg::*;

   logic [3:0] step_ff, step_in;
   ucode_type  uw;

   assign uw       = ucode_rom(step_ff);
   assign ctl.take = uw.take;
   assign ctl.op   = uw.op;

   always_comb begin
      case (uw.cond)
         C_ALWAYS:   step_in = uw.tgt_t;
         // hold until a transfer, then branch on its kind
         C_DISPATCH: step_in = !req_tvalid ? step_ff : (req_tuser ? uw.tgt_f : uw.tgt_t);
         C_FULL:     step_in = status.blk_full ? uw.tgt_t : uw.tgt_f;
         C_SPILL:    step_in = status.pad_spill ? uw.tgt_t : uw.tgt_f;
         C_ROUNDS:   step_in = status.round_last ? uw.tgt_t : step_ff;
         C_OUTFREE:  step_in = status.out_free ? uw.tgt_t : step_ff;
         default:    step_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/sha1bsh_dp.sv
// ----------------------------------------------------------------------------
// sha1bsh_dp
// Block buffer, schedule window, round logic, chaining words and result
// register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module sha1bsh_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1bsh_pkg::ctl_type     ctl,
   output sha1bsh_pkg::status_type  status,
   input  logic                     req_tvalid,
   input  logic [7:0]               req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [159:0]             rsp_tdata
);
   import sha1bsh_pkg::*;

   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];
   logic [31:0]  blk_ff [16];
   logic [31:0]  blk_in [16];
   logic [31:0]  win_ff [16];
   logic [31:0]  win_in [16];
   logic [60:0]  count_ff, count_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [7:0]   byte_ff, byte_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [159:0] rsp_data_ff, rsp_data_in;

   logic [5:0]   pos;
   logic [4:0]   lane_lo;
   logic [63:0]  bit_len;
   logic [31:0]  mix, sched, wt, f, k, tmp;
   logic         out_free;

   assign pos      = count_ff[5:0];
   assign lane_lo  = {~pos[1:0], 3'b000};
   assign bit_len  = {count_ff, 3'b000};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign status.blk_full   = &pos;
   assign status.pad_spill  = pos >= PAD_LIMIT;
   assign status.round_last = rnd_ff == ROUND_LAST;
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // window is a shift line: entry 15 is the newest word
   assign mix   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched = {mix[30:0], mix[31]};
   assign wt    = (rnd_ff < 7'd16) ? blk_ff[rnd_ff[3:0]] : sched;

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
   end

   assign tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + wt + k;

   always_comb begin
      chain_in     = chain_ff;
      blk_in       = blk_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      rnd_in       = rnd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      byte_in      = (ctl.take && req_tvalid) ? req_tdata : byte_ff;

      case (ctl.op)
         OP_PUTB: begin
            blk_in[pos[5:2]][lane_lo +: 8] = byte_ff;
            count_in = count_ff + 61'd1;
         end
         OP_PAD: begin
            blk_in[pos[5:2]][lane_lo +: 8] = PAD_BYTE;
         end
         OP_LOAD: begin
            a_in   = chain_ff[0];
            b_in   = chain_ff[1];
            c_in   = chain_ff[2];
            d_in   = chain_ff[3];
            e_in   = chain_ff[4];
            rnd_in = '0;
         end
         OP_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = wt;
            a_in   = tmp;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            rnd_in = rnd_ff + 7'd1;
         end
         OP_ADD, OP_ADDCLR: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (ctl.op == OP_ADDCLR) begin
               for (int i = 0; i < 16; i++) begin
                  blk_in[i] = '0;
               end
            end
         end
         OP_LENGTH: begin
            blk_in[14] = bit_len[63:32];
            blk_in[15] = bit_len[31:0];
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_data_in  = {chain_ff[4], chain_ff[3], chain_ff[2],
                               chain_ff[1], chain_ff[0]};
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 5; i++) begin
                  chain_in[i] = CHAIN_INIT[i];
               end
               for (int i = 0; i < 16; i++) begin
                  blk_in[i] = '0;
               end
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= CHAIN_INIT[i];
         end
         for (int i = 0; i < 16; i++) begin
            blk_ff[i] <= '0;
         end
         count_ff     <= '0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chain_ff     <= chain_in;
         blk_ff       <= blk_in;
         count_ff     <= count_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
